[src/byte_deque_with_reverse_unit_defines.svh]
// ---------------------------------------------------------------------------
// Byte deque assertion macros
// Shared property wrappers for the deque checker. The enclosing scope must
// provide clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef BYTE_DEQUE_WITH_REVERSE_UNIT_DEFINES_SVH
`define BYTE_DEQUE_WITH_REVERSE_UNIT_DEFINES_SVH

// same-cycle implication
`define BDQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdq: same-cycle check failed");

// next-cycle implication
`define BDQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdq: next-cycle check failed");

`endif

[src/bdq_pkg.sv]
// ---------------------------------------------------------------------------
// Byte deque package
// Widths, command codes, controller states and control/status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned DEPTH_DEF = 1024;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned FILL_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4,
    CMD_REVERSE    = 3'd5
  } bdq_cmd_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_MEM  = 1'b1
  } bdq_state_t;

  typedef struct packed {
    logic exec;
    logic load_direct;
    logic load_mem;
  } bdq_ctl_t;

  typedef struct packed {
    logic out_free;
    logic need_mem;
  } bdq_sts_t;

endpackage

`default_nettype wire

[src/bdq_in_if.sv]
// ---------------------------------------------------------------------------
// Byte deque command channel
// Valid/ready channel carrying one deque command.
// ---------------------------------------------------------------------------
`default_nettype none

interface bdq_in_if;
  import bdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] push_byte;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, output cmd, output push_byte, output read_index,
                  input ready);
  modport sink   (input valid, input cmd, input push_byte, input read_index,
                  output ready);
endinterface

`default_nettype wire

[src/bdq_out_if.sv]
// ---------------------------------------------------------------------------
// Byte deque result channel
// Valid/ready channel carrying one command result.
// ---------------------------------------------------------------------------
`default_nettype none

interface bdq_out_if;
  import bdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              ok;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, output out_byte, output ok, output fill_count,
                  input ready);
  modport sink   (input valid, input out_byte, input ok, input fill_count,
                  output ready);
endinterface

`default_nettype wire

[src/byte_deque_with_reverse_unit.sv]
// ---------------------------------------------------------------------------
// Byte deque with reverse
// Ring-buffer byte deque: push/pop at both ends, indexed read, and an
// orientation flip that swaps front and back without moving data.
// ---------------------------------------------------------------------------
//   channel  dir  handshake         payload
//   in_ch    in   valid/ready       cmd, push_byte, read_index
//   out_ch   out  valid/ready       out_byte, ok, fill_count
//
// Push, reverse and refused commands load their result directly; a new command
// can be taken while out_ch is free. Successful pop and read wait in ST_MEM for
// the registered read port of the byte store and take no new command meanwhile.
// Reset (rst_n low, synchronous) empties the deque and clears the flip flag;
// store contents are left as they are.
// A result waits in the output register; while it waits on a stalled out_ch,
// in_ch is held off.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_deque_with_reverse_unit #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);
  import bdq_pkg::*;

  bdq_ctl_t ctl;
  bdq_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_ch.cmd),
    .in_push_byte   (in_ch.push_byte),
    .in_read_index  (in_ch.read_index),
    .ctl            (ctl),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_ok         (out_ch.ok),
    .out_fill_count (out_ch.fill_count)
  );

endmodule

`default_nettype wire

[src/bdq_ram.sv]
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/bdq_ctrl.sv]
// ---------------------------------------------------------------------------
// Byte deque controller
// Sequences command acceptance and the ST_MEM wait for store reads.
// ---------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire bdq_pkg::bdq_sts_t sts,
  output      bdq_pkg::bdq_ctl_t ctl
);
  import bdq_pkg::*;

  bdq_state_t state_r;
  bdq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          ctl.exec = 1'b1;
          if (sts.need_mem) begin
            state_nxt = ST_MEM;
          end else begin
            ctl.load_direct = 1'b1;
          end
        end
      end
      ST_MEM: begin
        if (sts.out_free) begin
          ctl.load_mem = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/bdq_dpath.sv]
// ---------------------------------------------------------------------------
// Byte deque datapath
// Ring pointers, byte store, orientation flag and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bdq_dpath #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bdq_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [bdq_pkg::BYTE_W-1:0] in_push_byte,
  input  wire logic [bdq_pkg::IDX_W-1:0]  in_read_index,
  input  wire bdq_pkg::bdq_ctl_t          ctl,
  output      bdq_pkg::bdq_sts_t          sts,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [bdq_pkg::BYTE_W-1:0] out_byte,
  output      logic                       out_ok,
  output      logic [bdq_pkg::FILL_W-1:0] out_fill_count
);
  import bdq_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              rev_r, rev_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_ok_r;
  logic [FILL_W-1:0] out_fill_r;
  logic [FILL_W-1:0] pend_fill_r;

  bdq_cmd_t          cmd_e;
  logic              full, empty, in_range;
  logic              push_phys_front, pop_phys_front;
  logic [AW-1:0]     head_dec, head_inc;
  logic [CW-1:0]     count_m1;
  logic [CMPW-1:0]   idx_w, pos_w;
  logic [AW-1:0]     slot_back, slot_last, slot_pos;
  logic              ok_c, need_mem_c, we_c, re_c;
  logic [AW-1:0]     waddr_c, raddr_c;
  logic [BYTE_W-1:0] rdata;
  logic [FILL_W-1:0] fill_c;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign cmd_e           = bdq_cmd_t'(in_cmd);
  assign full            = (count_r == DEPTH_C);
  assign empty           = (count_r == '0);
  assign count_m1        = count_r - CW'(1);
  assign idx_w           = CMPW'(in_read_index);
  assign in_range        = (idx_w < CMPW'(count_r));
  assign pos_w           = rev_r ? (CMPW'(count_m1) - idx_w) : idx_w;
  assign push_phys_front = (cmd_e == CMD_PUSH_FRONT) ^ rev_r;
  assign pop_phys_front  = (cmd_e == CMD_POP_FRONT) ^ rev_r;
  assign head_dec        = (head_r == '0) ? LAST_PTR : (head_r - AW'(1));
  assign head_inc        = (head_r == LAST_PTR) ? '0 : (head_r + AW'(1));
  assign slot_back       = wrap(head_r, count_r[AW-1:0]);
  assign slot_last       = wrap(head_r, count_m1[AW-1:0]);
  assign slot_pos        = wrap(head_r, pos_w[AW-1:0]);

  always_comb begin
    ok_c       = 1'b0;
    need_mem_c = 1'b0;
    we_c       = 1'b0;
    re_c       = 1'b0;
    waddr_c    = slot_back;
    raddr_c    = slot_last;
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    unique case (cmd_e)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (!full) begin
          ok_c      = 1'b1;
          we_c      = 1'b1;
          count_nxt = count_r + CW'(1);
          if (push_phys_front) begin
            head_nxt = head_dec;
            waddr_c  = head_dec;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (!empty) begin
          ok_c       = 1'b1;
          need_mem_c = 1'b1;
          re_c       = 1'b1;
          count_nxt  = count_m1;
          if (pop_phys_front) begin
            raddr_c  = head_r;
            head_nxt = head_inc;
          end
        end
      end
      CMD_READ: begin
        if (in_range) begin
          ok_c       = 1'b1;
          need_mem_c = 1'b1;
          re_c       = 1'b1;
          raddr_c    = slot_pos;
        end
      end
      CMD_REVERSE: begin
        ok_c    = 1'b1;
        rev_nxt = ~rev_r;
      end
      default: begin
      end
    endcase
  end

  assign fill_c = FILL_W'(count_nxt);

  bdq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ctl.exec & we_c),
    .waddr   (waddr_c),
    .wdata   (in_push_byte),
    .re      (ctl.exec & re_c),
    .raddr   (raddr_c),
    .rdata_r (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.exec) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
        rev_r   <= rev_nxt;
      end
      if (ctl.load_direct || ctl.load_mem) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      pend_fill_r <= fill_c;
    end
    if (ctl.load_direct) begin
      out_byte_r <= '0;
      out_ok_r   <= ok_c;
      out_fill_r <= fill_c;
    end else if (ctl.load_mem) begin
      out_byte_r <= rdata;
      out_ok_r   <= 1'b1;
      out_fill_r <= pend_fill_r;
    end
  end

  assign sts.out_free = ~out_valid_r | out_ready;
  assign sts.need_mem = need_mem_c;

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_ok         = out_ok_r;
  assign out_fill_count = out_fill_r;

endmodule

`default_nettype wire

[src/bdq_checker.sv]
// ---------------------------------------------------------------------------
// Byte deque port checker
// Watches the result channel of the deque for result consistency over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "byte_deque_with_reverse_unit_defines.svh"

module bdq_checker #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [bdq_pkg::BYTE_W-1:0] out_byte,
  input wire logic                       out_ok,
  input wire logic [bdq_pkg::FILL_W-1:0] out_fill_count
);
  import bdq_pkg::*;

  logic [FILL_W-1:0] last_fill_r;
  logic [FILL_W-1:0] fill_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_fill_r <= '0;
    end else if (out_valid && out_ready) begin
      last_fill_r <= out_fill_count;
    end
  end

  assign fill_step = out_fill_count - last_fill_r;

  `BDQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_ok) && $stable(out_fill_count))
  `BDQ_ASSERT_IMP(a_refused_zero, out_valid && !out_ok, out_byte == '0)
  `BDQ_ASSERT_IMP(a_fill_bound, out_valid, 32'(out_fill_count) <= DEPTH)
  `BDQ_ASSERT_IMP(a_fill_step, out_valid, (fill_step == '0) || (fill_step == FILL_W'(1)) || (fill_step == '1))

endmodule

bind byte_deque_with_reverse_unit bdq_checker #(
  .DEPTH (DEPTH)
) u_bdq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte),
  .out_ok         (out_ch.ok),
  .out_fill_count (out_ch.fill_count)
);

`default_nettype wire

[test/bdq_result_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte deque result checker
// Watches the command and result channels. Each command transfer updates a
// shadow ring buffer and queues the predicted result. Each result transfer is
// compared field by field against the oldest queued prediction.
// ---------------------------------------------------------------------------
module bdq_result_checker (
  input  logic clk,
  input  logic rst_n,
  bdq_in_if    cmd_mon,
  bdq_out_if   res_mon,
  output int   mismatches,
  output int   outstanding
);
  import bdq_pkg::*;

  localparam int unsigned QDEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              ok;
    logic [FILL_W-1:0] fill_count;
  } deque_result_t;

  logic [BYTE_W-1:0] shadow_bytes [QDEPTH];
  logic [IDX_W-1:0]  shadow_head;
  logic [FILL_W-1:0] shadow_level;
  logic              shadow_flipped;

  deque_result_t     predicted_results [$];
  deque_result_t     want;
  int                n_results;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, n_results, msg);
    mismatches++;
  endtask

  function automatic deque_result_t apply_deque_cmd(input logic [CMD_W-1:0]  c,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [IDX_W-1:0]  ix);
    deque_result_t    r;
    logic             phys_front;
    logic [IDX_W-1:0] slot;
    r = '0;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_level < QDEPTH) begin
          phys_front = (c == CMD_PUSH_FRONT) ^ shadow_flipped;
          if (phys_front) begin
            shadow_head = shadow_head - 1'b1;
            slot        = shadow_head;
          end else begin
            slot = shadow_head + shadow_level[IDX_W-1:0];
          end
          shadow_bytes[slot] = b;
          shadow_level       = shadow_level + 1'b1;
          r.ok               = 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_level != 0) begin
          phys_front = (c == CMD_POP_FRONT) ^ shadow_flipped;
          if (phys_front) begin
            slot        = shadow_head;
            shadow_head = shadow_head + 1'b1;
          end else begin
            slot = shadow_head + shadow_level[IDX_W-1:0] - 1'b1;
          end
          r.out_byte   = shadow_bytes[slot];
          shadow_level = shadow_level - 1'b1;
          r.ok         = 1'b1;
        end
      end
      CMD_READ: begin
        if (ix < shadow_level) begin
          // flipped: position counted from the physical back
          if (shadow_flipped)
            slot = shadow_head + shadow_level[IDX_W-1:0] - 1'b1 - ix;
          else
            slot = shadow_head + ix;
          r.out_byte = shadow_bytes[slot];
          r.ok       = 1'b1;
        end
      end
      CMD_REVERSE: begin
        shadow_flipped = ~shadow_flipped;
        r.ok           = 1'b1;
      end
      default: ;
    endcase
    r.fill_count = shadow_level;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_head    = '0;
      shadow_level   = '0;
      shadow_flipped = 1'b0;
      predicted_results.delete();
      n_results      = 0;
      mismatches     = 0;
      outstanding   <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result transfer with no command outstanding");
        end else begin
          want = predicted_results.pop_front();
          if (res_mon.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte got %02h want %02h",
                                      res_mon.out_byte, want.out_byte));
          if (res_mon.ok !== want.ok)
            report_mismatch($sformatf("ok got %b want %b", res_mon.ok, want.ok));
          if (res_mon.fill_count !== want.fill_count)
            report_mismatch($sformatf("fill_count got %0d want %0d",
                                      res_mon.fill_count, want.fill_count));
        end
        n_results++;
      end
      if (cmd_mon.valid && cmd_mon.ready)
        predicted_results.push_back(apply_deque_cmd(cmd_mon.cmd, cmd_mon.push_byte,
                                                    cmd_mon.read_index));
      outstanding <= predicted_results.size();
    end
  end

endmodule

[test/tb_byte_deque_with_reverse_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte deque with reverse testbench
// Directed corner commands, then a small-depth random walk, a fill to full
// depth and a pop-heavy mix under three idle profiles, with one long result
// stall. Prediction and comparison live in the result checker.
// ---------------------------------------------------------------------------
module tb_byte_deque_with_reverse_unit;
  import bdq_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 10;
  localparam int          STALL_CYCLES = 250;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int unsigned QDEPTH       = DEPTH_DEF;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  int mismatches;
  int outstanding;

  int send_idle_pct  = 7;
  int recv_idle_pct  = 70;
  bit stall_request  = 1'b0;
  bit hold_off       = 1'b0;
  int stim_level     = 0;
  int n_sent         = 0;
  int full_refusals  = 0;
  int empty_refusals = 0;
  int cycle_count    = 0;

  byte_deque_with_reverse_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bdq_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_mon     (in_ch),
    .res_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long result stall so the block backs up into the command channel
  initial begin
    wait (stall_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_cmd(input logic [CMD_W-1:0]  c,
                          input logic [BYTE_W-1:0] b,
                          input logic [IDX_W-1:0]  ix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.push_byte  <= b;
    in_ch.read_index <= ix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK:
        if (stim_level < QDEPTH) stim_level++;
        else full_refusals++;
      CMD_POP_FRONT, CMD_POP_BACK:
        if (stim_level > 0) stim_level--;
        else empty_refusals++;
      default: ;
    endcase
  endtask

  task automatic send_random(input int push_pct, input int pop_pct);
    int               roll;
    logic [CMD_W-1:0] c;
    logic [IDX_W-1:0] ix;
    roll = $urandom_range(99);
    ix   = IDX_W'($urandom_range(QDEPTH - 1));
    if (roll < push_pct) begin
      c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        c = CMD_READ;
        if (stim_level > 0 && $urandom_range(1))
          ix = IDX_W'($urandom_range(stim_level - 1));
      end else if (roll < 85) begin
        c = CMD_REVERSE;
      end else begin
        c = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      end
    end
    send_cmd(c, BYTE_W'($urandom), ix);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_PUSH_FRONT;
    in_ch.push_byte  = '0;
    in_ch.read_index = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty deque: refused pops, out-of-range read, unused codes
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '1, '1);
    send_cmd(CMD_READ, '0, '0);
    send_cmd(CMD_SPARE_LO, '1, '1);
    send_cmd(CMD_SPARE_HI, '0, '0);
    // push at both ends, head wraps below zero on the first front push
    send_cmd(CMD_PUSH_FRONT, 8'h00, '0);
    send_cmd(CMD_PUSH_BACK, 8'hff, '0);
    send_cmd(CMD_PUSH_FRONT, 8'ha5, '0);
    send_cmd(CMD_PUSH_BACK, 8'h5a, '0);
    send_cmd(CMD_READ, '0, 10'd0);
    send_cmd(CMD_READ, '0, 10'd3);
    send_cmd(CMD_READ, '0, 10'd4);
    send_cmd(CMD_READ, '0, '1);
    // reversed orientation
    send_cmd(CMD_REVERSE, '0, '0);
    send_cmd(CMD_READ, '0, 10'd0);
    send_cmd(CMD_READ, '0, 10'd3);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_PUSH_FRONT, 8'h3c, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_REVERSE, '0, '0);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_READ, '0, 10'd0);

    // shallow random walk, empty refusals are frequent here
    repeat (250) send_random(40, 40);

    send_idle_pct = 70;
    recv_idle_pct = 7;
    while (stim_level < QDEPTH) send_random(92, 2);
    repeat (8)
      send_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
               BYTE_W'($urandom), IDX_W'($urandom));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    repeat (300) send_random(30, 45);
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands over three idle profiles and a %0d-cycle result stall",
             n_sent, STALL_CYCLES);
    $display("Filled to %0d bytes; %0d pushes refused as full, %0d pops refused as empty",
             QDEPTH, full_refusals, empty_refusals);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
